FILE: rtl/uavp_pkg.sv
// uavp_pkg: shared types, character codes and length constants for the
// avp parameter value locator. No dependencies.
`timescale 1ns / 1ps

package uavp_pkg;

   // Longest string scanned; later bytes only set the overflow flag.
   localparam int MAX_STRING_LEN = 1024;
   // Position counter must hold MAX_STRING_LEN itself.
   localparam int POS_W          = $clog2(MAX_STRING_LEN + 1);

   // Result field widths (fixed by the port definition).
   localparam int OFFSET_W = 10;
   localparam int LENGTH_W = 11;

   localparam logic [7:0] CH_LO_A   = 8'h61; // 'a'
   localparam logic [7:0] CH_UP_A   = 8'h41; // 'A'
   localparam logic [7:0] CH_LO_V   = 8'h76; // 'v'
   localparam logic [7:0] CH_UP_V   = 8'h56; // 'V'
   localparam logic [7:0] CH_LO_P   = 8'h70; // 'p'
   localparam logic [7:0] CH_UP_P   = 8'h50; // 'P'
   localparam logic [7:0] CH_SEMI   = 8'h3B; // ';'
   localparam logic [7:0] CH_EQ     = 8'h3D; // '='
   localparam logic [7:0] CH_BSLASH = 8'h5C; // backslash
   localparam logic [7:0] CH_DQUOTE = 8'h22; // double quote
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef enum logic [3:0] {
      ST_NAME     = 4'd0,
      ST_A        = 4'd1,
      ST_AV       = 4'd2,
      ST_AVP      = 4'd3,
      ST_PRE_EQ   = 4'd4,
      ST_POST_EQ  = 4'd5,
      ST_SKIP     = 4'd6,
      ST_SKIP_Q   = 4'd7,
      ST_SKIP_ESC = 4'd8,
      ST_BARE     = 4'd9,
      ST_QUOTED   = 4'd10,
      ST_Q_ESC    = 4'd11
   } scan_state_type;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] value_offset;
      logic [LENGTH_W-1:0] value_length;
      logic                too_long;
   } scan_result_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

endpackage

FILE: rtl/uavp_scanner.sv
// uavp_scanner: per-byte parameter scanner state and the result of the
// transfer in hand. Depends on uavp_pkg.
`timescale 1ns / 1ps

module uavp_scanner
   import uavp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      data_byte,
   input  logic            has_byte,
   input  logic            last,
   output scan_result_type result
);

   scan_state_type   state_ff, state_in, state_step, upd_state;
   logic [POS_W-1:0] pos_ff, pos_in, upd_pos;
   logic [POS_W-1:0] start_ff, start_in, upd_start;
   logic [POS_W-1:0] vlen_ff, vlen_in, upd_vlen;
   logic [POS_W-1:0] res_len;
   logic             fin_ff, fin_in, upd_fin;
   logic             ovf_ff, ovf_in, upd_ovf;
   logic             at_max, step_en;
   logic             load_start, start_skip, end_zero, end_pos;

   assign at_max  = (pos_ff >= POS_W'(MAX_STRING_LEN));
   assign step_en = has_byte && !at_max && !fin_ff;

   // Next state of the scanner for one byte
   always_comb begin
      state_step = state_ff;
      unique case (state_ff)
         ST_NAME: begin
            if (!is_ws(data_byte)) begin
               state_step = (data_byte == CH_LO_A || data_byte == CH_UP_A) ? ST_A : ST_SKIP;
            end
         end
         ST_A: begin
            state_step = (data_byte == CH_LO_V || data_byte == CH_UP_V) ? ST_AV : ST_SKIP;
         end
         ST_AV: begin
            state_step = (data_byte == CH_LO_P || data_byte == CH_UP_P) ? ST_AVP : ST_SKIP;
         end
         ST_AVP, ST_PRE_EQ: begin
            priority if (data_byte == CH_SEMI) state_step = state_ff;
            else if (data_byte == CH_EQ)       state_step = ST_POST_EQ;
            else if (is_ws(data_byte))         state_step = ST_PRE_EQ;
            else                               state_step = ST_SKIP;
         end
         ST_POST_EQ: begin
            priority if (data_byte == CH_DQUOTE) state_step = ST_QUOTED;
            else if (data_byte == CH_SEMI)       state_step = state_ff;
            else if (is_ws(data_byte))           state_step = state_ff;
            else                                 state_step = ST_BARE;
         end
         ST_SKIP: begin
            priority if (data_byte == CH_DQUOTE) state_step = ST_SKIP_Q;
            else if (data_byte == CH_SEMI)       state_step = ST_NAME;
            else                                 state_step = state_ff;
         end
         ST_SKIP_Q: begin
            priority if (data_byte == CH_BSLASH) state_step = ST_SKIP_ESC;
            else if (data_byte == CH_DQUOTE)     state_step = ST_SKIP;
            else                                 state_step = state_ff;
         end
         ST_SKIP_ESC: state_step = ST_SKIP_Q;
         ST_BARE:     state_step = state_ff;
         ST_QUOTED: begin
            if (data_byte == CH_BSLASH) state_step = ST_Q_ESC;
         end
         ST_Q_ESC:    state_step = ST_QUOTED;
         default:     state_step = ST_NAME;
      endcase
   end

   // Actions: value start capture and value end
   always_comb begin
      load_start = 1'b0;
      start_skip = 1'b0;
      end_zero   = 1'b0;
      end_pos    = 1'b0;
      unique case (state_ff)
         ST_AVP, ST_PRE_EQ: begin
            end_zero = (data_byte == CH_SEMI);
         end
         ST_POST_EQ: begin
            priority if (data_byte == CH_DQUOTE) begin
               load_start = 1'b1;
               start_skip = 1'b1;
            end else if (data_byte == CH_SEMI) begin
               end_zero = 1'b1;
            end else if (!is_ws(data_byte)) begin
               load_start = 1'b1;
            end else begin
               load_start = 1'b0;
            end
         end
         ST_BARE: begin
            priority if (data_byte == CH_DQUOTE) end_zero = 1'b1;
            else if (data_byte == CH_SEMI || is_ws(data_byte)) end_pos = 1'b1;
            else end_pos = 1'b0;
         end
         ST_QUOTED: begin
            end_pos = (data_byte == CH_DQUOTE);
         end
         default: begin
            load_start = 1'b0;
         end
      endcase
   end

   // Updated scan registers after this transfer
   always_comb begin
      upd_state = step_en ? state_step : state_ff;
      upd_start = start_ff;
      if (step_en && load_start) begin
         upd_start = start_skip ? pos_ff + POS_W'(1) : pos_ff;
      end
      upd_vlen = vlen_ff;
      if (step_en && end_zero) begin
         upd_vlen = '0;
      end else if (step_en && end_pos) begin
         upd_vlen = pos_ff - start_ff;
      end
      upd_fin = fin_ff || (step_en && (end_zero || end_pos));
      upd_pos = (has_byte && !at_max) ? pos_ff + POS_W'(1) : pos_ff;
      upd_ovf = ovf_ff || (has_byte && at_max);
   end

   // An open bare value runs to the end of the string
   assign res_len = (!upd_fin && upd_state == ST_BARE) ? upd_pos - upd_start : upd_vlen;

   always_comb begin
      result.found        = (res_len != '0);
      result.value_offset = result.found ? OFFSET_W'(upd_start) : '0;
      result.value_length = result.found ? LENGTH_W'(res_len) : '0;
      result.too_long     = upd_ovf;
   end

   // Last transfer of a string returns the scanner to its reset state
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      vlen_in  = vlen_ff;
      fin_in   = fin_ff;
      ovf_in   = ovf_ff;
      if (accept && last) begin
         state_in = ST_NAME;
         pos_in   = '0;
         start_in = '0;
         vlen_in  = '0;
         fin_in   = 1'b0;
         ovf_in   = 1'b0;
      end else if (accept) begin
         state_in = upd_state;
         pos_in   = upd_pos;
         start_in = upd_start;
         vlen_in  = upd_vlen;
         fin_in   = upd_fin;
         ovf_in   = upd_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NAME;
         pos_ff   <= '0;
         start_ff <= '0;
         vlen_ff  <= '0;
         fin_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         vlen_ff  <= vlen_in;
         fin_ff   <= fin_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

FILE: rtl/uri_avp_param_value_locator.sv
// uri_avp_param_value_locator: top level, handshake and result register.
// Depends on uavp_pkg and uavp_scanner.
//
//   channel | direction | ports                                    | transfer
//   --------+-----------+------------------------------------------+---------------------
//   req     | in        | data_byte, has_byte, last                | req_valid & !req_stall
//   rsp     | out       | found, value_offset, value_length, too_long | rsp_valid & !rsp_stall
//
// One byte per cycle, sustained, but for a last transfer stalled behind a held result.
// The scanner state registers take each transfer; the result of a last
// transfer lands in the result register and shows on rsp_* the next cycle.
// Reset is synchronous, active high: scanner to name start, result register empty.
// req_stall rises only for a last transfer while a held result is stalled;
// other bytes keep flowing. No item without last ever yields a result.
`timescale 1ns / 1ps

module uri_avp_param_value_locator
   import uavp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_has_byte,
   input  logic                req_last,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [OFFSET_W-1:0] rsp_value_offset,
   output logic [LENGTH_W-1:0] rsp_value_length,
   output logic                rsp_too_long
);

   scan_result_type scan_res;
   scan_result_type res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_accept, rsp_held;

   // A result waiting on a stalled consumer blocks only another result
   assign rsp_held   = rsp_valid_ff && rsp_stall;
   assign req_stall  = rsp_held && req_last;
   assign req_accept = req_valid && !req_stall;

   uavp_scanner u_scanner (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .has_byte  (req_has_byte),
      .last      (req_last),
      .result    (scan_res)
   );

   // Result register: load on a last transfer, drain when taken
   always_comb begin
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept && req_last) begin
         res_in       = scan_res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = res_ff.found;
   assign rsp_value_offset = res_ff.value_offset;
   assign rsp_value_length = res_ff.value_length;
   assign rsp_too_long     = res_ff.too_long;

   // Every last transfer produces a result in the next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) |=> rsp_valid)
      else $error("last transfer did not produce a result");

   // Bytes without last never create a result
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && !req_stall && req_last) && !(rsp_valid && rsp_stall)) |=> !rsp_valid)
      else $error("result appeared without a last transfer");

   // Not found reports zero offset and length; found has a non-empty value
   a_found_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found ? (rsp_value_length != '0)
                               : (rsp_value_length == '0 && rsp_value_offset == '0)))
      else $error("result fields inconsistent with found");

endmodule

FILE: verif/uri_avp_param_value_locator_test.sv
// uri_avp_param_value_locator_test: self-checking bench for the avp value locator.
// Depends on uavp_pkg and the uri_avp_param_value_locator RTL; needs no files or arguments.
// Directed strings from a table, then random parameter strings, scored against a predictor.
`timescale 1ns / 1ps

module uri_avp_param_value_locator_test;
   import uavp_pkg::*;

   localparam int HALF_PERIOD  = 2;     // 4 ns clock
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 250;   // random transfers offered after the directed and back-pressure parts
   localparam int QUIET_ITEMS  = 80;    // tail of the run with no idling on either side
   localparam int LONG_HOLD    = 120;   // one long response hold-off, in cycles
   localparam int HOLD_STRINGS = 6;     // strings offered while the response side is held
   localparam int STALL_LIMIT  = 2000;  // cycles without any transfer before giving up
   localparam int DRAIN_CYCLES = 8;     // settle time after the last result
   localparam int NUM_PROBES   = 20;

   // ---------------------------------------------------------------------------------
   // DUT ports; every input is known from time zero
   // ---------------------------------------------------------------------------------
   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = 8'h00;
   logic                req_has_byte  = 1'b0;
   logic                req_last      = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic                rsp_found;
   logic [OFFSET_W-1:0] rsp_value_offset;
   logic [LENGTH_W-1:0] rsp_value_length;
   logic                rsp_too_long;

   uri_avp_param_value_locator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_value_offset (rsp_value_offset),
      .rsp_value_length (rsp_value_length),
      .rsp_too_long     (rsp_too_long)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------------------
   scan_result_type pending_values[$];  // expected results, oldest first
   logic [7:0]      text_buf[$];        // bytes of the string being offered
   bit              idle_on       = 1'b1;
   bit              use_typed     = 1'b0;
   scan_result_type typed_want;
   bit              long_hold_req = 1'b0;
   int              mismatch_count = 0;
   int              items_sent     = 0;
   int              strings_sent   = 0;
   int              values_found   = 0;
   int              over_length    = 0;

   // ---------------------------------------------------------------------------------
   // Predictor: a byte-level copy of the scanner, at the block's widths
   // ---------------------------------------------------------------------------------
   scan_state_type   sc_state  = ST_NAME;
   logic [POS_W-1:0] sc_pos    = '0;
   logic [POS_W-1:0] sc_vstart = '0;  // one wider than the offset port: may hold MAX
   logic [POS_W-1:0] sc_vlen   = '0;
   bit               sc_done   = 1'b0;
   bit               sc_ovf    = 1'b0;

   function automatic bit blank_char(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic void close_value(input logic [POS_W-1:0] len);
      sc_vlen = len;
      sc_done = 1'b1;
   endfunction

   function automatic void scan_char(input logic [7:0] c);
      case (sc_state)
         ST_NAME: begin
            if (!blank_char(c))
               sc_state = (c == CH_LO_A || c == CH_UP_A) ? ST_A : ST_SKIP;
         end
         ST_A:  sc_state = (c == CH_LO_V || c == CH_UP_V) ? ST_AV : ST_SKIP;
         ST_AV: sc_state = (c == CH_LO_P || c == CH_UP_P) ? ST_AVP : ST_SKIP;
         ST_AVP, ST_PRE_EQ: begin
            if (c == CH_SEMI) close_value('0);
            else if (c == CH_EQ) sc_state = ST_POST_EQ;
            else if (blank_char(c)) sc_state = ST_PRE_EQ;
            else sc_state = ST_SKIP;
         end
         ST_POST_EQ: begin
            if (c == CH_DQUOTE) begin
               sc_state  = ST_QUOTED;
               sc_vstart = sc_pos + POS_W'(1);
            end else if (c == CH_SEMI) begin
               close_value('0);
            end else if (!blank_char(c)) begin
               sc_state  = ST_BARE;
               sc_vstart = sc_pos;
            end
         end
         ST_SKIP: begin
            if (c == CH_DQUOTE) sc_state = ST_SKIP_Q;
            else if (c == CH_SEMI) sc_state = ST_NAME;
         end
         ST_SKIP_Q: begin
            if (c == CH_BSLASH) sc_state = ST_SKIP_ESC;
            else if (c == CH_DQUOTE) sc_state = ST_SKIP;
         end
         ST_SKIP_ESC: sc_state = ST_SKIP_Q;
         ST_BARE: begin
            if (c == CH_DQUOTE) close_value('0);
            else if (c == CH_SEMI || blank_char(c)) close_value(sc_pos - sc_vstart);
         end
         ST_QUOTED: begin
            if (c == CH_DQUOTE) close_value(sc_pos - sc_vstart);
            else if (c == CH_BSLASH) sc_state = ST_Q_ESC;
         end
         ST_Q_ESC: sc_state = ST_QUOTED;
         default:  sc_state = ST_NAME;
      endcase
   endfunction

   // Advances the predictor by one transfer; returns 1 with the result on a last item.
   function automatic bit avp_scan_step(input logic [7:0] d, input logic h, input logic l,
                                        output scan_result_type r);
      logic [POS_W-1:0] len;
      r = '0;
      if (h) begin
         if (sc_pos >= MAX_STRING_LEN) begin
            sc_ovf = 1'b1;
         end else begin
            if (!sc_done) scan_char(d);
            sc_pos = sc_pos + POS_W'(1);
         end
      end
      if (!l) return 1'b0;
      len = sc_vlen;
      // a bare value still open runs to the end of the scanned bytes
      if (!sc_done && sc_state == ST_BARE) len = sc_pos - sc_vstart;
      r.found        = len != 0;
      r.value_offset = r.found ? sc_vstart[OFFSET_W-1:0] : '0;
      r.value_length = r.found ? len : '0;
      r.too_long     = sc_ovf;
      sc_state  = ST_NAME;
      sc_pos    = '0;
      sc_vstart = '0;
      sc_vlen   = '0;
      sc_done   = 1'b0;
      sc_ovf    = 1'b0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Random string builder
   // ---------------------------------------------------------------------------------
   function automatic logic [7:0] any_case(input logic [7:0] upper);
      return $urandom_range(0, 1) ? upper : (upper | CH_SPACE);  // 0x20 flips the case
   endfunction

   function automatic logic [7:0] blank_pick();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   // printable token byte; a stray quote now and then
   function automatic logic [7:0] token_pick();
      logic [7:0] c;
      if ($urandom_range(0, 24) == 0) return CH_DQUOTE;
      do c = 8'($urandom_range(8'h21, 8'h7E));
      while (c == CH_SEMI || c == CH_DQUOTE);
      return c;
   endfunction

   function automatic void add_blanks();
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) text_buf.push_back(blank_pick());
   endfunction

   // Mostly well-formed param lists, avp heavily favored, with some noise mixed in.
   function automatic void compose_params();
      int n_par;
      text_buf = {};
      n_par = $urandom_range(0, 4);
      for (int k = 0; k < n_par; k++) begin
         if (k > 0) text_buf.push_back(CH_SEMI);
         add_blanks();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               text_buf.push_back(any_case(CH_UP_A));
               text_buf.push_back(any_case(CH_UP_V));
               text_buf.push_back(any_case(CH_UP_P));
            end
            5: begin  // cut-off name
               text_buf.push_back(any_case(CH_UP_A));
               if ($urandom_range(0, 1)) text_buf.push_back(any_case(CH_UP_V));
            end
            6: begin  // name with avp as prefix only
               text_buf.push_back(any_case(CH_UP_A));
               text_buf.push_back(any_case(CH_UP_V));
               text_buf.push_back(any_case(CH_UP_P));
               text_buf.push_back(token_pick());
            end
            default: repeat ($urandom_range(1, 4))
               text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
         endcase
         add_blanks();
         if ($urandom_range(0, 5) != 0) begin
            text_buf.push_back(CH_EQ);
            add_blanks();
            case ($urandom_range(0, 5))
               0, 1, 2: repeat ($urandom_range(1, 6)) text_buf.push_back(token_pick());
               3: begin  // quoted, with escapes, separators and blanks inside
                  text_buf.push_back(CH_DQUOTE);
                  repeat ($urandom_range(0, 6)) begin
                     case ($urandom_range(0, 7))
                        0: begin
                           text_buf.push_back(CH_BSLASH);
                           text_buf.push_back(8'($urandom_range(0, 255)));
                        end
                        1:       text_buf.push_back(CH_SEMI);
                        2:       text_buf.push_back(blank_pick());
                        default: text_buf.push_back(token_pick());
                     endcase
                  end
                  if ($urandom_range(0, 7) != 0) text_buf.push_back(CH_DQUOTE);
               end
               4: ;  // empty value
               default: repeat ($urandom_range(1, 4))
                  text_buf.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
      if ($urandom_range(0, 5) == 0)
         text_buf.insert($urandom_range(0, text_buf.size()), 8'($urandom_range(0, 255)));
   endfunction

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------
   // One transfer. Valid may drop for a short burst first; payload holds while stalled.
   task automatic send_item(input logic [7:0] d, input logic h, input logic l);
      scan_result_type r;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_has_byte  <= h;
      req_last      <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (avp_scan_step(d, h, l, r)) begin
         if (use_typed) r = typed_want;
         pending_values.push_back(r);
         if (r.found) values_found++;
         if (r.too_long) over_length++;
      end
   endtask

   // Offers text_buf as one string. A byte-less item may be slipped in somewhere, and
   // the string may close with a byte-less last item instead of last on its final byte.
   task automatic send_string(input bit hole, input bit tail_end);
      int hole_at;
      hole_at = (hole && text_buf.size() > 0) ? $urandom_range(0, text_buf.size() - 1) : -1;
      for (int i = 0; i < text_buf.size(); i++) begin
         if (i == hole_at) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(text_buf[i], 1'b1, !tail_end && i == text_buf.size() - 1);
      end
      if (tail_end || text_buf.size() == 0)
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      strings_sent++;
   endtask

   // Sender pause: drop valid and wait for every outstanding result.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (pending_values.size() != 0);
   endtask

   // ---------------------------------------------------------------------------------
   // Response side: scoring and stall pattern
   // ---------------------------------------------------------------------------------
   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   scan_result_type next_due;
   int              hold_left  = 0;
   int              stall_left = 0;
   bit              hold_taken = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_values.size() == 0) begin
               report_mismatch("result with none pending", 1, 0);
            end else begin
               next_due = pending_values.pop_front();
               if (rsp_found !== next_due.found)
                  report_mismatch("found", rsp_found, next_due.found);
               if (rsp_value_offset !== next_due.value_offset)
                  report_mismatch("value_offset", rsp_value_offset, next_due.value_offset);
               if (rsp_value_length !== next_due.value_length)
                  report_mismatch("value_length", rsp_value_length, next_due.value_length);
               if (rsp_too_long !== next_due.too_long)
                  report_mismatch("too_long", rsp_too_long, next_due.too_long);
            end
         end
         // the one long hold-off is timed here, independent of the sender
         if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);  // random stall burst
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Watchdog: any stretch with no transfer on either channel is a hang
   // ---------------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer in %0d cycles, %0d results outstanding",
                  STALL_LIMIT, pending_values.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Directed strings. Rows with typed = 1 carry their own expected result; the rest
   // are scored by the predictor.
   // ---------------------------------------------------------------------------------
   typedef struct {
      string           text;
      int              pad_count;  // copies of pad_char appended to text
      logic [7:0]      pad_char;
      bit              hole;       // byte-less item somewhere inside
      bit              tail_end;   // close with a byte-less last item
      bit              typed;
      scan_result_type want;
   } probe_row_type;

   probe_row_type probe_rows [NUM_PROBES] = '{
      // empty string: a single byte-less last item
      '{"",                        0,    8'h00, 0, 1, 1, {1'b0, 10'd0, 11'd0,    1'b0}},
      '{"avp=abc",                 0,    8'h00, 0, 0, 1, {1'b1, 10'd4, 11'd3,    1'b0}},
      // quoted value with an escaped quote inside, any letter case, blanks around '='
      '{"AvP = \"x\\\"y\";q",      0,    8'h00, 0, 0, 0, '0},
      // bare avp: ';' right after the name, after blanks, right after '='
      '{"avp;x=1",                 0,    8'h00, 0, 0, 1, {1'b0, 10'd0, 11'd0,    1'b0}},
      '{"avp=;",                   0,    8'h00, 0, 0, 1, {1'b0, 10'd0, 11'd0,    1'b0}},
      '{"avp =  ;",                0,    8'h00, 0, 0, 1, {1'b0, 10'd0, 11'd0,    1'b0}},
      // quote inside a bare value kills it
      '{"avp=ab\"c",               0,    8'h00, 0, 0, 1, {1'b0, 10'd0, 11'd0,    1'b0}},
      // empty quoted value, then unterminated quoted value
      '{"avp=\"\"",                0,    8'h00, 0, 0, 1, {1'b0, 10'd0, 11'd0,    1'b0}},
      '{"avp=\"abc",               0,    8'h00, 0, 0, 1, {1'b0, 10'd0, 11'd0,    1'b0}},
      // avp hidden in a skipped quoted string, with and without an escape
      '{"x=\"a;avp=1\";avp=zz",    0,    8'h00, 0, 0, 0, '0},
      '{"x=\"\\\";avp=1\";avp=q",  0,    8'h00, 0, 0, 0, '0},
      // every blank kind; only the first avp counts, later bytes ignored
      '{" \t\015\012avp\t=\tv1 ;avp=v2", 0, 8'h00, 0, 0, 0, '0},
      // names that only start like avp
      '{"avpx=1;av=2;a;avp=ok",    0,    8'h00, 0, 0, 0, '0},
      // bare value open at the end: closed by a byte-less last, then with a byte-less item inside
      '{"avp=tail",                0,    8'h00, 0, 1, 1, {1'b1, 10'd4, 11'd4,    1'b0}},
      '{"avp=v",                   0,    8'h00, 1, 0, 0, '0},
      // byte extremes as value content
      '{"avp=",                    2,    8'hFF, 0, 0, 1, {1'b1, 10'd4, 11'd2,    1'b0}},
      '{"avp=",                    3,    8'h00, 0, 0, 1, {1'b1, 10'd4, 11'd3,    1'b0}},
      '{"aVp=Q",                   0,    8'h00, 0, 0, 0, '0},
      '{"xyz",                     0,    8'h00, 0, 0, 1, {1'b0, 10'd0, 11'd0,    1'b0}},
      // over-length with the bare value still open: it ends at the maximum
      '{"avp=x",                   1021, 8'h79, 0, 0, 1, {1'b1, 10'd4, 11'd1020, 1'b1}}
   };

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      int target;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (probe_rows[r]) begin
         text_buf = {};
         for (int j = 0; j < probe_rows[r].text.len(); j++)
            text_buf.push_back(probe_rows[r].text[j]);
         repeat (probe_rows[r].pad_count) text_buf.push_back(probe_rows[r].pad_char);
         use_typed  = probe_rows[r].typed;
         typed_want = probe_rows[r].want;
         send_string(probe_rows[r].hole, probe_rows[r].tail_end);
      end
      use_typed = 1'b0;
      wait_drained();

      // back-pressure: response side holds off while strings keep coming, so the
      // result register fills and the next last transfer stalls on the request side
      long_hold_req = 1'b1;
      repeat (HOLD_STRINGS) begin
         compose_params();
         send_string(1'b0, 1'b0);
      end
      wait_drained();

      // random part
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         idle_on = items_sent + QUIET_ITEMS < target;
         compose_params();
         send_string($urandom_range(0, 9) == 0, $urandom_range(0, 4) == 0);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d strings in %0d transfers: %0d values located, %0d over-length.",
               strings_sent, items_sent, values_found, over_length);
      $display("Back-pressure hold of %0d cycles exercised; %0d mismatches.",
               LONG_HOLD, mismatch_count);
      if (mismatch_count == 0 && pending_values.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/uavp_pkg.sv
rtl/uavp_scanner.sv
rtl/uri_avp_param_value_locator.sv
verif/uri_avp_param_value_locator_test.sv
